@@ sv/cse_pkg.sv @@
// ---------------------------------------------------------------------------
// cse_pkg
// Shared types and codes of the 8-bit cpu subset execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

	localparam int unsigned OP_W   = 6;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ADDR_W = 16;

	localparam int unsigned IN_W  = OP_W + MODE_W + 3 * BYTE_W + ADDR_W;
	localparam int unsigned OUT_W = 56;

	localparam logic [OP_W-1:0] OP_CMP = 6'd0;
	localparam logic [OP_W-1:0] OP_CPX = 6'd1;
	localparam logic [OP_W-1:0] OP_CPY = 6'd2;
	localparam logic [OP_W-1:0] OP_ADC = 6'd3;
	localparam logic [OP_W-1:0] OP_SBC = 6'd4;
	localparam logic [OP_W-1:0] OP_INC = 6'd5;
	localparam logic [OP_W-1:0] OP_INX = 6'd6;
	localparam logic [OP_W-1:0] OP_INY = 6'd7;
	localparam logic [OP_W-1:0] OP_DEC = 6'd8;
	localparam logic [OP_W-1:0] OP_DEX = 6'd9;
	localparam logic [OP_W-1:0] OP_DEY = 6'd10;
	localparam logic [OP_W-1:0] OP_CLC = 6'd11;
	localparam logic [OP_W-1:0] OP_CLV = 6'd12;
	localparam logic [OP_W-1:0] OP_SEC = 6'd13;
	localparam logic [OP_W-1:0] OP_LDA = 6'd14;
	localparam logic [OP_W-1:0] OP_STA = 6'd15;
	localparam logic [OP_W-1:0] OP_STX = 6'd16;
	localparam logic [OP_W-1:0] OP_STY = 6'd17;
	localparam logic [OP_W-1:0] OP_LDX = 6'd18;
	localparam logic [OP_W-1:0] OP_LDY = 6'd19;
	localparam logic [OP_W-1:0] OP_BCS = 6'd22;
	localparam logic [OP_W-1:0] OP_BCC = 6'd23;
	localparam logic [OP_W-1:0] OP_BMI = 6'd24;
	localparam logic [OP_W-1:0] OP_BPL = 6'd25;
	localparam logic [OP_W-1:0] OP_BVS = 6'd26;
	localparam logic [OP_W-1:0] OP_BVC = 6'd27;
	localparam logic [OP_W-1:0] OP_BEQ = 6'd28;
	localparam logic [OP_W-1:0] OP_BNE = 6'd29;
	localparam logic [OP_W-1:0] OP_JMP = 6'd30;
	localparam logic [OP_W-1:0] OP_TXA = 6'd31;
	localparam logic [OP_W-1:0] OP_TAX = 6'd32;
	localparam logic [OP_W-1:0] OP_TYA = 6'd33;
	localparam logic [OP_W-1:0] OP_TAY = 6'd34;

	localparam logic [MODE_W-1:0] MODE_IMM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ZP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REL = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ABS = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] operand_low;
		logic [BYTE_W-1:0] operand_high;
		logic [ADDR_W-1:0] pc;
		logic [BYTE_W-1:0] mem_data;
	} instr_t;

	typedef struct packed {
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] x_index;
		logic [BYTE_W-1:0] y_index;
		logic              carry;
		logic              zero;
		logic              negative;
		logic              overflow;
	} regs_t;

	typedef struct packed {
		logic              mem_write;
		logic [BYTE_W-1:0] mem_write_data;
		logic              branch_taken;
	} ctrl_t;

endpackage

`default_nettype wire

@@ sv/cse_addr_gen.sv @@
// ---------------------------------------------------------------------------
// cse_addr_gen
// Effective address for the four addressing modes.
// ---------------------------------------------------------------------------
`default_nettype none

module cse_addr_gen (
	input  wire logic [cse_pkg::MODE_W-1:0] mode,
	input  wire logic [cse_pkg::BYTE_W-1:0] operand_low,
	input  wire logic [cse_pkg::BYTE_W-1:0] operand_high,
	input  wire logic [cse_pkg::ADDR_W-1:0] pc,
	output logic      [cse_pkg::ADDR_W-1:0] eff_address
);
	import cse_pkg::*;

	logic [ADDR_W-1:0] offset;

	assign offset = {{(ADDR_W-BYTE_W){operand_low[BYTE_W-1]}}, operand_low};

	always_comb begin
		unique case (mode)
			MODE_IMM: eff_address = pc + ADDR_W'(1);
			MODE_ZP:  eff_address = {{(ADDR_W-BYTE_W){1'b0}}, operand_low};
			MODE_REL: eff_address = pc + offset;
			MODE_ABS: eff_address = {operand_high, operand_low};
			default:  eff_address = {operand_high, operand_low};
		endcase
	end

endmodule

`default_nettype wire

@@ sv/cse_exec_logic.sv @@
// ---------------------------------------------------------------------------
// cse_exec_logic
// Operation decode, byte alu, compares, branch test and next register state.
// ---------------------------------------------------------------------------
`default_nettype none

module cse_exec_logic (
	input  wire logic [cse_pkg::OP_W-1:0]   op,
	input  wire logic [cse_pkg::BYTE_W-1:0] mem_data,
	input  wire cse_pkg::regs_t             cur,
	output cse_pkg::regs_t                  nxt,
	output cse_pkg::ctrl_t                  ctrl
);
	import cse_pkg::*;

	logic [BYTE_W-1:0] add_b;
	logic [BYTE_W:0]   sum;
	logic [BYTE_W-1:0] cmp_reg;
	logic [BYTE_W:0]   diff;

	assign add_b = (op == OP_SBC) ? ~mem_data : mem_data;
	assign sum   = {1'b0, cur.acc} + {1'b0, add_b} + {{BYTE_W{1'b0}}, cur.carry};

	always_comb begin
		unique case (op)
			OP_CPX:  cmp_reg = cur.x_index;
			OP_CPY:  cmp_reg = cur.y_index;
			default: cmp_reg = cur.acc;
		endcase
	end

	assign diff = {1'b0, cmp_reg} - {1'b0, mem_data};

	always_comb begin
		nxt  = cur;
		ctrl = '0;
		unique case (op)
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.carry    = ~diff[BYTE_W];
				nxt.zero     = (diff[BYTE_W-1:0] == '0);
				nxt.negative = diff[BYTE_W-1];
			end
			OP_ADC, OP_SBC: begin
				nxt.acc      = sum[BYTE_W-1:0];
				nxt.carry    = sum[BYTE_W];
				nxt.zero     = (sum[BYTE_W-1:0] == '0);
				nxt.negative = sum[BYTE_W-1];
				nxt.overflow = (cur.acc[BYTE_W-1] ^ sum[BYTE_W-1])
					& (add_b[BYTE_W-1] ^ sum[BYTE_W-1]);
			end
			OP_INC: begin
				ctrl.mem_write      = 1'b1;
				ctrl.mem_write_data = mem_data + BYTE_W'(1);
			end
			OP_DEC: begin
				ctrl.mem_write      = 1'b1;
				ctrl.mem_write_data = mem_data - BYTE_W'(1);
			end
			OP_INX: nxt.x_index = cur.x_index + BYTE_W'(1);
			OP_INY: nxt.y_index = cur.y_index + BYTE_W'(1);
			OP_DEX: nxt.x_index = cur.x_index - BYTE_W'(1);
			OP_DEY: nxt.y_index = cur.y_index - BYTE_W'(1);
			OP_CLC: nxt.carry = 1'b0;
			OP_CLV: nxt.overflow = 1'b0;
			OP_SEC: nxt.carry = 1'b1;
			OP_LDA: nxt.acc = mem_data;
			OP_LDX: nxt.x_index = mem_data;
			OP_LDY: nxt.y_index = mem_data;
			OP_STA: begin
				ctrl.mem_write      = 1'b1;
				ctrl.mem_write_data = cur.acc;
			end
			OP_STX: begin
				ctrl.mem_write      = 1'b1;
				ctrl.mem_write_data = cur.x_index;
			end
			OP_STY: begin
				ctrl.mem_write      = 1'b1;
				ctrl.mem_write_data = cur.y_index;
			end
			OP_BCS: ctrl.branch_taken = cur.carry;
			OP_BCC: ctrl.branch_taken = ~cur.carry;
			OP_BMI: ctrl.branch_taken = cur.negative;
			OP_BPL: ctrl.branch_taken = ~cur.negative;
			OP_BVS: ctrl.branch_taken = cur.overflow;
			OP_BVC: ctrl.branch_taken = ~cur.overflow;
			OP_BEQ: ctrl.branch_taken = cur.zero;
			OP_BNE: ctrl.branch_taken = ~cur.zero;
			OP_JMP: ctrl.branch_taken = 1'b1;
			OP_TXA: nxt.acc = cur.x_index;
			OP_TAX: nxt.x_index = cur.acc;
			OP_TYA: nxt.acc = cur.y_index;
			OP_TAY: nxt.y_index = cur.acc;
			default: begin
				nxt  = cur;
				ctrl = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/cpu8_subset_execute_unit.sv @@
// ---------------------------------------------------------------------------
// cpu8_subset_execute_unit
// Execute stage of an 8-bit accumulator cpu subset, one instruction per item.
// ---------------------------------------------------------------------------
// Each accepted request is one decoded instruction. It is captured in an input
// register, executed against A, X, Y and the C, Z, N, V flags by byte-wide add,
// compare and mux logic, and its result is then registered in an output
// register. A new request can be taken every clock while the output is not
// stalled: the architectural registers update in the same edge that moves an
// instruction into the output register, so the next instruction sees them at
// once. The feedback through the 8-bit adder and flag logic sets the clock
// limit. Backpressure on the output side stalls both stages; the input stays
// ready whenever the output register is empty or being drained.
`default_nettype none

module cpu8_subset_execute_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// op[5:0], mode[7:6], operand_low[15:8], operand_high[23:16],
	// pc[39:24], mem_data[47:40]
	input  wire logic [cse_pkg::IN_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// eff_address[15:0], mem_write[16], mem_write_data[24:17],
	// branch_taken[25], acc_out[33:26], x_out[41:34], y_out[49:42],
	// carry_out[50], zero_out[51], negative_out[52], overflow_out[53], zero pad
	output logic      [cse_pkg::OUT_W-1:0]  m_tdata
);
	import cse_pkg::*;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [BYTE_W-1:0] operand_low_s1;
	logic [BYTE_W-1:0] operand_high_s1;
	logic [ADDR_W-1:0] pc_s1;
	logic [BYTE_W-1:0] mem_data_s1;

	logic              valid_s2;
	logic [ADDR_W-1:0] eff_address_s2;
	ctrl_t             ctrl_s2;
	regs_t             regs_s2;

	regs_t             regs_q;
	regs_t             regs_nxt;
	ctrl_t             ctrl_nxt;
	logic [ADDR_W-1:0] eff_address;

	logic              out_ready;
	logic              advance;
	logic              s_accept;

	assign out_ready = ~valid_s2 | m_tready;
	assign advance   = valid_s1 & out_ready;
	assign s_tready  = ~valid_s1 | out_ready;
	assign s_accept  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			{mem_data_s1, pc_s1, operand_high_s1, operand_low_s1, mode_s1, op_s1}
				<= s_tdata;
		end
	end

	cse_addr_gen u_addr (
		.mode         (mode_s1),
		.operand_low  (operand_low_s1),
		.operand_high (operand_high_s1),
		.pc           (pc_s1),
		.eff_address  (eff_address)
	);

	cse_exec_logic u_exec (
		.op       (op_s1),
		.mem_data (mem_data_s1),
		.cur      (regs_q),
		.nxt      (regs_nxt),
		.ctrl     (ctrl_nxt)
	);

	// architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (advance) begin
			regs_q <= regs_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			eff_address_s2 <= eff_address;
			ctrl_s2        <= ctrl_nxt;
			regs_s2        <= regs_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {
		2'b00,
		regs_s2.overflow,
		regs_s2.negative,
		regs_s2.zero,
		regs_s2.carry,
		regs_s2.y_index,
		regs_s2.x_index,
		regs_s2.acc,
		ctrl_s2.branch_taken,
		ctrl_s2.mem_write_data,
		ctrl_s2.mem_write,
		eff_address_s2
	};

endmodule

`default_nettype wire

@@ sv/cse_checker.sv @@
// ---------------------------------------------------------------------------
// cse_checker
// Port-level checks of the execute unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cse_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic [cse_pkg::IN_W-1:0]  s_tdata,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [cse_pkg::OUT_W-1:0] m_tdata
);
	import cse_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// write data is zero without a write
	a_wdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[16] |-> m_tdata[24:17] == 8'h00)
		else $error("write data without write");

	// no instruction both writes memory and branches
	a_wr_branch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[16] && m_tdata[25]))
		else $error("write and branch together");

	// accepted request reaches the output when the sink stays ready meanwhile
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing after request");

endmodule

bind cpu8_subset_execute_unit cse_checker u_cse_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the cpu8 subset execute unit. A short table of
// instructions covers every operation, address mode, wrap and flag edge, then
// about 1600 random instructions follow. Each request is run through a shadow
// copy of A, X, Y and the flags, and every result is compared field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cse_pkg::*;

	localparam logic [OP_W-1:0] OP_NOOP    = 6'd20;
	localparam logic [OP_W-1:0] OP_BRK     = 6'd21;
	localparam logic [OP_W-1:0] OP_RTS     = 6'd35;
	localparam logic [OP_W-1:0] OP_FREE_LO = 6'd36;
	localparam logic [OP_W-1:0] OP_FREE_HI = 6'd63;

	localparam int N_DIRECTED  = 39;
	localparam int N_RANDOM    = 1600;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 8;

	// packed so that op lands in the low bits of tdata
	typedef struct packed {
		logic [BYTE_W-1:0] mem_data;
		logic [ADDR_W-1:0] pc;
		logic [BYTE_W-1:0] operand_high;
		logic [BYTE_W-1:0] operand_low;
		logic [MODE_W-1:0] mode;
		logic [OP_W-1:0]   op;
	} cpu_instr_t;

	typedef struct packed {
		logic [ADDR_W-1:0] eff_address;
		logic              mem_write;
		logic [BYTE_W-1:0] mem_write_data;
		logic              branch_taken;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] x_index;
		logic [BYTE_W-1:0] y_index;
		logic              carry;
		logic              zero;
		logic              negative;
		logic              overflow;
	} exec_result_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] operand_low;
		logic [BYTE_W-1:0] operand_high;
		logic [ADDR_W-1:0] pc;
		logic [BYTE_W-1:0] mem_data;
		logic              typed;
		exec_result_t      want;
	} directed_row_t;

	localparam exec_result_t UNTYPED = '0;

	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{OP_NOOP, MODE_IMM, 8'h00, 8'h00, 16'hFFFF, 8'h00, 1'b1,
			'{16'h0000, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_LDA, MODE_IMM, 8'h00, 8'h00, 16'h1234, 8'hFF, 1'b1,
			'{16'h1235, 1'b0, 8'h00, 1'b0, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{OP_ADC, MODE_ABS, 8'hFF, 8'hFF, 16'h0000, 8'h01, 1'b1,
			'{16'hFFFF, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{OP_BEQ, MODE_REL, 8'h80, 8'h00, 16'h0010, 8'h00, 1'b1,
			'{16'hFF90, 1'b0, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{OP_BCS, MODE_REL, 8'h7F, 8'h00, 16'hFFF0, 8'h00, 1'b1,
			'{16'h006F, 1'b0, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{OP_STA, MODE_ZP, 8'hFF, 8'h00, 16'h0000, 8'h00, 1'b1,
			'{16'h00FF, 1'b1, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
		'{OP_CLC, MODE_ZP,  8'h80, 8'h00, 16'h0300, 8'h55, 1'b0, UNTYPED},
		'{OP_LDA, MODE_IMM, 8'h00, 8'h00, 16'h0100, 8'h7F, 1'b0, UNTYPED},
		'{OP_ADC, MODE_IMM, 8'h00, 8'h00, 16'h0102, 8'h01, 1'b0, UNTYPED},
		'{OP_BVS, MODE_REL, 8'h05, 8'h00, 16'h0200, 8'h00, 1'b0, UNTYPED},
		'{OP_BMI, MODE_REL, 8'hFB, 8'h00, 16'h0200, 8'h00, 1'b0, UNTYPED},
		'{OP_CLV, MODE_IMM, 8'h00, 8'h00, 16'h0204, 8'h00, 1'b0, UNTYPED},
		'{OP_BVC, MODE_REL, 8'h10, 8'h00, 16'h8000, 8'h00, 1'b0, UNTYPED},
		'{OP_SEC, MODE_IMM, 8'h00, 8'h00, 16'h0206, 8'h00, 1'b0, UNTYPED},
		'{OP_SBC, MODE_ZP,  8'h00, 8'h00, 16'h0400, 8'h01, 1'b0, UNTYPED},
		'{OP_BPL, MODE_REL, 8'h20, 8'h00, 16'h0500, 8'h00, 1'b0, UNTYPED},
		'{OP_BCC, MODE_REL, 8'hE0, 8'h00, 16'h0500, 8'h00, 1'b0, UNTYPED},
		'{OP_LDX, MODE_IMM, 8'h00, 8'h00, 16'h0600, 8'h00, 1'b0, UNTYPED},
		'{OP_DEX, MODE_IMM, 8'h00, 8'h00, 16'h0602, 8'h00, 1'b0, UNTYPED},
		'{OP_INX, MODE_IMM, 8'h00, 8'h00, 16'h0603, 8'h00, 1'b0, UNTYPED},
		'{OP_LDY, MODE_ABS, 8'h34, 8'h12, 16'h0700, 8'hFF, 1'b0, UNTYPED},
		'{OP_INY, MODE_IMM, 8'h00, 8'h00, 16'h0703, 8'h00, 1'b0, UNTYPED},
		'{OP_DEY, MODE_IMM, 8'h00, 8'h00, 16'h0704, 8'h00, 1'b0, UNTYPED},
		'{OP_CPX, MODE_IMM, 8'h00, 8'h00, 16'h0800, 8'h00, 1'b0, UNTYPED},
		'{OP_CPY, MODE_IMM, 8'h00, 8'h00, 16'h0802, 8'h00, 1'b0, UNTYPED},
		'{OP_CMP, MODE_IMM, 8'h00, 8'h00, 16'h0804, 8'hFF, 1'b0, UNTYPED},
		'{OP_BNE, MODE_REL, 8'h02, 8'h00, 16'h0900, 8'h00, 1'b0, UNTYPED},
		'{OP_INC, MODE_ABS, 8'hFF, 8'h00, 16'h0A00, 8'hFF, 1'b0, UNTYPED},
		'{OP_DEC, MODE_ABS, 8'h00, 8'hFF, 16'h0A03, 8'h00, 1'b0, UNTYPED},
		'{OP_STX, MODE_ZP,  8'h10, 8'h00, 16'h0B00, 8'h00, 1'b0, UNTYPED},
		'{OP_STY, MODE_ABS, 8'hCD, 8'hAB, 16'h0B02, 8'h00, 1'b0, UNTYPED},
		'{OP_TXA, MODE_IMM, 8'h00, 8'h00, 16'h0C00, 8'h00, 1'b0, UNTYPED},
		'{OP_TAX, MODE_IMM, 8'h00, 8'h00, 16'h0C01, 8'h00, 1'b0, UNTYPED},
		'{OP_TYA, MODE_IMM, 8'h00, 8'h00, 16'h0C02, 8'h00, 1'b0, UNTYPED},
		'{OP_TAY, MODE_IMM, 8'h00, 8'h00, 16'h0C03, 8'h00, 1'b0, UNTYPED},
		'{OP_JMP, MODE_ABS, 8'h00, 8'hC0, 16'h0C04, 8'h00, 1'b0, UNTYPED},
		'{OP_BRK, MODE_IMM, 8'hAA, 8'h55, 16'hC000, 8'hFF, 1'b0, UNTYPED},
		'{OP_RTS, MODE_ZP,  8'h55, 8'hAA, 16'hC001, 8'hFF, 1'b0, UNTYPED},
		'{OP_FREE_HI, MODE_ABS, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, UNTYPED}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;

	// side info that travels with the request beside s_tdata
	logic               req_typed = 1'b0;
	exec_result_t       req_want = '0;

	exec_result_t       pending_results [$];
	int                 failures = 0;
	int                 idle_cycles = 0;
	bit                 steady = 1'b0;

	logic [BYTE_W-1:0]  cpu_acc = '0;
	logic [BYTE_W-1:0]  cpu_x = '0;
	logic [BYTE_W-1:0]  cpu_y = '0;
	logic               cpu_c = 1'b0;
	logic               cpu_z = 1'b0;
	logic               cpu_n = 1'b0;
	logic               cpu_v = 1'b0;

	cpu8_subset_execute_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void compare_to(input logic [BYTE_W-1:0] reg_val,
			input logic [BYTE_W-1:0] m);
		logic [BYTE_W-1:0] diff;
		diff  = reg_val - m;
		cpu_c = (reg_val >= m);
		cpu_z = (diff == '0);
		cpu_n = diff[7];
	endfunction

	function automatic exec_result_t execute_instr(input cpu_instr_t ins);
		exec_result_t r;
		logic [BYTE_W-1:0] addend;
		logic [BYTE_W:0]   sum;
		r = '0;
		case (ins.mode)
			MODE_IMM: r.eff_address = ins.pc + 16'd1;
			MODE_ZP:  r.eff_address = {8'h00, ins.operand_low};
			MODE_REL: r.eff_address = ins.pc + {{8{ins.operand_low[7]}}, ins.operand_low};
			default:  r.eff_address = {ins.operand_high, ins.operand_low};
		endcase
		case (ins.op)
			OP_CMP: compare_to(cpu_acc, ins.mem_data);
			OP_CPX: compare_to(cpu_x, ins.mem_data);
			OP_CPY: compare_to(cpu_y, ins.mem_data);
			OP_ADC, OP_SBC: begin
				addend  = (ins.op == OP_SBC) ? ~ins.mem_data : ins.mem_data;
				sum     = {1'b0, cpu_acc} + {1'b0, addend} + {8'h00, cpu_c};
				cpu_v   = (cpu_acc[7] ^ sum[7]) & (addend[7] ^ sum[7]);
				cpu_c   = sum[8];
				cpu_acc = sum[7:0];
				cpu_z   = (sum[7:0] == '0);
				cpu_n   = sum[7];
			end
			OP_INC: begin
				r.mem_write      = 1'b1;
				r.mem_write_data = ins.mem_data + 8'd1;
			end
			OP_DEC: begin
				r.mem_write      = 1'b1;
				r.mem_write_data = ins.mem_data - 8'd1;
			end
			OP_INX: cpu_x = cpu_x + 8'd1;
			OP_INY: cpu_y = cpu_y + 8'd1;
			OP_DEX: cpu_x = cpu_x - 8'd1;
			OP_DEY: cpu_y = cpu_y - 8'd1;
			OP_CLC: cpu_c = 1'b0;
			OP_CLV: cpu_v = 1'b0;
			OP_SEC: cpu_c = 1'b1;
			OP_LDA: cpu_acc = ins.mem_data;
			OP_LDX: cpu_x = ins.mem_data;
			OP_LDY: cpu_y = ins.mem_data;
			OP_STA: begin
				r.mem_write      = 1'b1;
				r.mem_write_data = cpu_acc;
			end
			OP_STX: begin
				r.mem_write      = 1'b1;
				r.mem_write_data = cpu_x;
			end
			OP_STY: begin
				r.mem_write      = 1'b1;
				r.mem_write_data = cpu_y;
			end
			OP_BCS: r.branch_taken = cpu_c;
			OP_BCC: r.branch_taken = ~cpu_c;
			OP_BMI: r.branch_taken = cpu_n;
			OP_BPL: r.branch_taken = ~cpu_n;
			OP_BVS: r.branch_taken = cpu_v;
			OP_BVC: r.branch_taken = ~cpu_v;
			OP_BEQ: r.branch_taken = cpu_z;
			OP_BNE: r.branch_taken = ~cpu_z;
			OP_JMP: r.branch_taken = 1'b1;
			OP_TXA: cpu_acc = cpu_x;
			OP_TAX: cpu_x = cpu_acc;
			OP_TYA: cpu_acc = cpu_y;
			OP_TAY: cpu_y = cpu_acc;
			default: ;
		endcase
		r.acc      = cpu_acc;
		r.x_index  = cpu_x;
		r.y_index  = cpu_y;
		r.carry    = cpu_c;
		r.zero     = cpu_z;
		r.negative = cpu_n;
		r.overflow = cpu_v;
		return r;
	endfunction

	function automatic exec_result_t unpack_result(input logic [OUT_W-1:0] d);
		exec_result_t r;
		r.eff_address    = d[15:0];
		r.mem_write      = d[16];
		r.mem_write_data = d[24:17];
		r.branch_taken   = d[25];
		r.acc            = d[33:26];
		r.x_index        = d[41:34];
		r.y_index        = d[49:42];
		r.carry          = d[50];
		r.zero           = d[51];
		r.negative       = d[52];
		r.overflow       = d[53];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
			failures++;
		end
	endfunction

	function automatic void check_result(input exec_result_t want, input exec_result_t got);
		check_field("eff_address", want.eff_address, got.eff_address);
		check_field("mem_write", 16'(want.mem_write), 16'(got.mem_write));
		check_field("mem_write_data", 16'(want.mem_write_data),
			16'(got.mem_write_data));
		check_field("branch_taken", 16'(want.branch_taken), 16'(got.branch_taken));
		check_field("acc_out", 16'(want.acc), 16'(got.acc));
		check_field("x_out", 16'(want.x_index), 16'(got.x_index));
		check_field("y_out", 16'(want.y_index), 16'(got.y_index));
		check_field("carry_out", 16'(want.carry), 16'(got.carry));
		check_field("zero_out", 16'(want.zero), 16'(got.zero));
		check_field("negative_out", 16'(want.negative), 16'(got.negative));
		check_field("overflow_out", 16'(want.overflow), 16'(got.overflow));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		if ($urandom_range(0, 4) != 0)
			return BYTE_W'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'h7F;
			2:       return 8'h80;
			default: return 8'hFF;
		endcase
	endfunction

	function automatic cpu_instr_t random_instr();
		cpu_instr_t ins;
		if ($urandom_range(0, 99) < 92)
			ins.op = OP_W'($urandom_range(OP_CMP, OP_RTS));
		else
			ins.op = OP_W'($urandom_range(OP_FREE_LO, OP_FREE_HI));
		ins.mode         = MODE_W'($urandom_range(0, 3));
		ins.operand_low  = pick_byte();
		ins.operand_high = pick_byte();
		ins.mem_data     = pick_byte();
		if ($urandom_range(0, 9) == 0)
			ins.pc = $urandom_range(0, 1) ? 16'(16'hFFFF - $urandom_range(0, 3)) :
				16'($urandom_range(0, 3));
		else
			ins.pc = 16'($urandom_range(0, 16'hFFFF));
		return ins;
	endfunction

	task automatic send_instr(input cpu_instr_t ins, input logic typed,
			input exec_result_t want, input int gap, input bit drain);
		if (drain && gap == 0)
			gap = 1;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && pending_results.size() != 0)
				@(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= ins;
		req_typed <= typed;
		req_want  <= want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// results are checked before the request of the same edge is predicted
	always @(posedge clk) begin : scoreboard
		exec_result_t got;
		exec_result_t predicted;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = unpack_result(m_tdata);
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result: expected none actual %h", $time, m_tdata);
					failures++;
				end else begin
					check_result(pending_results.pop_front(), got);
				end
			end
			if (s_tvalid && s_tready) begin
				predicted = execute_instr(cpu_instr_t'(s_tdata));
				pending_results.push_back(req_typed ? req_want : predicted);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t timeout, %0d results outstanding", $time, pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : sink_pacing
		int run;
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 24);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = steady ? 0 : pick_gap();
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : source
		cpu_instr_t ins;
		int gap;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			ins.op           = DIRECTED[i].op;
			ins.mode         = DIRECTED[i].mode;
			ins.operand_low  = DIRECTED[i].operand_low;
			ins.operand_high = DIRECTED[i].operand_high;
			ins.pc           = DIRECTED[i].pc;
			ins.mem_data     = DIRECTED[i].mem_data;
			send_instr(ins, DIRECTED[i].typed, DIRECTED[i].want, pick_gap(), 1'b0);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			// back-to-back stretch with the sink always ready
			steady = (i >= 1000 && i < 1200);
			gap = steady ? 0 : pick_gap();
			send_instr(random_instr(), 1'b0, UNTYPED, gap, i == N_RANDOM / 2);
		end
		steady = 1'b0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
sv/cse_pkg.sv
sv/cse_addr_gen.sv
sv/cse_exec_logic.sv
sv/cpu8_subset_execute_unit.sv
sv/cse_checker.sv
verif/tb.sv
